[rtl/simple_moving_average_defines.svh]
// Assertion macros shared by the moving average RTL.
// Define ASSERT_OFF to compile all checks out; no other dependencies.
`ifndef SIMPLE_MOVING_AVERAGE_DEFINES_SVH
`define SIMPLE_MOVING_AVERAGE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SMA_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("moving average check failed");
`define SMA_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("moving average check failed");
`else
`define SMA_ASSERT_ALWAYS(label, clk, rst, expr)
`define SMA_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

[rtl/smavg_pkg.sv]
// Shared constants, types and helpers for the moving average block.
// No dependencies; used by every module under rtl.
package smavg_pkg;

   localparam int SAMPLE_W     = 32;
   localparam int SUM_W        = 40;
   localparam int LEN_W        = 9;
   localparam int MAX_WINDOW   = 256;
   localparam int PTR_W        = 8;
   localparam int RESET_LENGTH = 30;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QCNT_W       = 2;
   localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                sample_valid;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] dividend;
      logic [LEN_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] value);
      logic [LEN_W-1:0] result;
      if (value == '0) begin
         result = LEN_W'(1);
      end else if (value > LEN_W'(MAX_WINDOW)) begin
         result = LEN_W'(MAX_WINDOW);
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

[rtl/smavg_front.sv]
// Front end: accepts items, tags them valid or NaN, and queues them.
// Depends on smavg_pkg and simple_moving_average_defines.svh.
`include "simple_moving_average_defines.svh"

module smavg_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [smavg_pkg::SAMPLE_W-1:0] req_tdata,
   input  logic                           req_tuser,
   output smavg_pkg::queue_head_type      head,
   input  logic                           pop
);

   smavg_pkg::item_type entries_ff [smavg_pkg::QUEUE_DEPTH];
   logic [smavg_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                         wr_ptr_ff, wr_ptr_in;
   logic                         rd_ptr_ff, rd_ptr_in;
   logic                         push;
   logic                         do_pop;

   assign req_tready = (count_ff < smavg_pkg::QCNT_W'(smavg_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff].sample       <= req_tdata;
         entries_ff[wr_ptr_ff].sample_valid <= req_tuser;
      end
   end

   `SMA_ASSERT_NEXT(a_count_up, clock, reset, push && !do_pop, count_ff == $past(count_ff) + 1'b1)
   `SMA_ASSERT_ALWAYS(a_count_max, clock, reset, count_ff <= smavg_pkg::QCNT_W'(smavg_pkg::QUEUE_DEPTH))

endmodule

[rtl/smavg_div.sv]
// Restoring divider: signed window sum by unsigned length, one bit per cycle.
// Depends on smavg_pkg and simple_moving_average_defines.svh.
`include "simple_moving_average_defines.svh"

module smavg_div (
   input  logic                   clock,
   input  logic                   reset,
   input  smavg_pkg::div_req_type req,
   output smavg_pkg::div_rsp_type rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [smavg_pkg::DIV_CNT_W-1:0]     count_ff, count_in;
   logic                                neg_ff, neg_in;
   logic [smavg_pkg::SUM_W-1:0]         quo_ff, quo_in;
   logic [smavg_pkg::LEN_W-1:0]         rem_ff, rem_in;
   logic [smavg_pkg::LEN_W-1:0]         divisor_ff, divisor_in;
   logic [smavg_pkg::LEN_W:0]           trial;
   logic                                fits;
   logic [smavg_pkg::SAMPLE_W-1:0]      mag;

   assign trial = {rem_ff, quo_ff[smavg_pkg::SUM_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      neg_in     = neg_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = smavg_pkg::DIV_CNT_W'(smavg_pkg::SUM_W);
         neg_in     = req.dividend[smavg_pkg::SUM_W-1];
         quo_in     = req.dividend[smavg_pkg::SUM_W-1] ? 
                      smavg_pkg::SUM_W'(-req.dividend) : smavg_pkg::SUM_W'(req.dividend);
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[smavg_pkg::SUM_W-2:0], fits};
         rem_in   = fits ? smavg_pkg::LEN_W'(trial - {1'b0, divisor_ff})
                         : smavg_pkg::LEN_W'(trial);
         count_in = count_ff - 1'b1;
         if (count_ff == smavg_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      neg_ff     <= neg_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign mag          = quo_ff[smavg_pkg::SAMPLE_W-1:0];
   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? -mag : mag;

   `SMA_ASSERT_ALWAYS(a_busy_count, clock, reset, !busy_ff || (count_ff != '0))

endmodule

[rtl/smavg_back.sv]
// Back end: window memory, running sum, fill and pointer, result staging.
// Depends on smavg_pkg, smavg_div and simple_moving_average_defines.svh.
`include "simple_moving_average_defines.svh"

module smavg_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [smavg_pkg::LEN_W-1:0]     csr_wr_data,
   input  smavg_pkg::queue_head_type       head,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [smavg_pkg::SAMPLE_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIV,
      ST_SEND
   } state_type;

   state_type                          state_ff;
   logic [smavg_pkg::LEN_W-1:0]        len_ff;
   logic [smavg_pkg::LEN_W-1:0]        fill_ff;
   logic [smavg_pkg::PTR_W-1:0]        wp_ff;
   logic signed [smavg_pkg::SUM_W-1:0] sum_ff;
   logic                               full_ff;
   logic signed [smavg_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [smavg_pkg::SAMPLE_W-1:0] old_ff;
   logic [smavg_pkg::SAMPLE_W-1:0]     res_avg_ff;
   logic                               res_valid_ff;
   logic                               rsp_tvalid_ff;
   logic [smavg_pkg::SAMPLE_W-1:0]     rsp_tdata_ff;
   logic                               rsp_tuser_ff;
   logic [smavg_pkg::SAMPLE_W-1:0]     window_mem [smavg_pkg::MAX_WINDOW];

   logic [smavg_pkg::LEN_W-1:0]        wp_wide;
   logic [smavg_pkg::LEN_W-1:0]        wp_next;
   logic [smavg_pkg::LEN_W-1:0]        fill_next;
   logic signed [smavg_pkg::SUM_W-1:0] sum_in;
   logic                               take;
   logic                               out_free;
   logic                               send;
   smavg_pkg::div_req_type             div_req;
   smavg_pkg::div_rsp_type             div_rsp;

   assign wp_wide   = {1'b0, wp_ff};
   assign wp_next   = (wp_wide + 1'b1 == len_ff) ? '0 : wp_wide + 1'b1;
   assign fill_next = full_ff ? fill_ff : fill_ff + 1'b1;
   assign sum_in    = sum_ff + smavg_pkg::SUM_W'(sample_ff)
                      - (full_ff ? smavg_pkg::SUM_W'(old_ff) : '0);
   assign pop       = (state_ff == ST_IDLE) && head.valid;
   assign take      = pop && head.item.sample_valid;
   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign send      = (state_ff == ST_SEND) && out_free;

   assign div_req.start    = (state_ff == ST_START);
   assign div_req.dividend = sum_ff;
   assign div_req.divisor  = len_ff;

   smavg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (take) begin
         window_mem[wp_ff] <= head.item.sample;
      end
      old_ff <= window_mem[wp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= smavg_pkg::LEN_W'(smavg_pkg::RESET_LENGTH);
         fill_ff       <= '0;
         wp_ff         <= '0;
         sum_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (send) begin
            rsp_tvalid_ff <= 1'b1;
            rsp_tdata_ff  <= res_avg_ff;
            rsp_tuser_ff  <= res_valid_ff;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (head.item.sample_valid) begin
                     sample_ff <= head.item.sample;
                     full_ff   <= (fill_ff >= len_ff);
                     state_ff  <= ST_UPDATE;
                  end else begin
                     res_avg_ff   <= '0;
                     res_valid_ff <= 1'b0;
                     state_ff     <= ST_SEND;
                  end
               end
            end
            ST_UPDATE: begin
               if (fill_next >= len_ff) begin
                  state_ff <= ST_START;
               end else begin
                  res_avg_ff   <= '0;
                  res_valid_ff <= 1'b0;
                  state_ff     <= ST_SEND;
               end
            end
            ST_START: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_rsp.done) begin
                  res_avg_ff   <= div_rsp.quotient;
                  res_valid_ff <= 1'b1;
                  state_ff     <= ST_SEND;
               end
            end
            ST_SEND: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (csr_wr_en) begin
            len_ff  <= smavg_pkg::clamp_length(csr_wr_data);
            fill_ff <= '0;
            wp_ff   <= '0;
            sum_ff  <= '0;
         end else if (state_ff == ST_UPDATE) begin
            sum_ff  <= sum_in;
            fill_ff <= fill_next;
            wp_ff   <= wp_next[smavg_pkg::PTR_W-1:0];
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `SMA_ASSERT_ALWAYS(a_wp_range, clock, reset, wp_wide < len_ff)
   `SMA_ASSERT_ALWAYS(a_fill_range, clock, reset, fill_ff <= len_ff)

endmodule

[rtl/simple_moving_average.sv]
// Simple moving average: a NaN item goes from idle straight to send, a filling
// item passes through update, a full-window item through update, start and the
// bit-serial divider. The back end takes one item at a time; a 2-entry queue
// and the output register let the input take items while results wait.
// Reset: synchronous, clears control, sum, fill count and pointer; length is 30.
// The window memory is not cleared; entries are read only once written.
module simple_moving_average (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,  // window_length
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // sample
   input  logic        req_tuser,    // sample_valid
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // average
   output logic        rsp_tuser     // average_valid
);

   smavg_pkg::queue_head_type head;
   logic                      pop;

   smavg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   smavg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head        (head),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
